// File: hdl/bbr_pkg.sv
// Shared types and constants for the box-to-robot-position pipeline.
// No dependencies; imported by every module under hdl/.
package bbr_pkg;

  // Widths of the arithmetic.
  localparam int NUM_W    = 37;               // dividend and quotient width
  localparam int DIV_W    = 16;               // divisor (box height) width
  localparam int COEF_W   = 16;               // Q2.14 rotation coefficient
  localparam int ROW_W    = 3 * COEF_W;       // packed rotation row
  localparam int POS_W    = 32;               // Q16.16 position
  localparam int ROT_FRAC = 14;               // fraction bits of the coefficients
  localparam int PROD_W   = COEF_W + NUM_W + 1;
  localparam int SUM_W    = PROD_W + 1;
  localparam int NUM_AXES = 3;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_FOCAL   = 4'd0,
    REG_HEIGHT  = 4'd1,
    REG_ROT0    = 4'd2,
    REG_ROT1    = 4'd3,
    REG_ROT2    = 4'd4,
    REG_SHIFT_X = 4'd5,
    REG_SHIFT_Y = 4'd6,
    REG_SHIFT_Z = 4'd7
  } cfg_reg_t;

  localparam logic [15:0]      FOCAL_RESET  = 16'd8000;
  localparam logic [15:0]      HEIGHT_RESET = 16'd6963;
  localparam logic [ROW_W-1:0] ROT0_RESET   = 48'd16384;
  localparam logic [ROW_W-1:0] ROT1_RESET   = 48'd1073741824;
  localparam logic [ROW_W-1:0] ROT2_RESET   = 48'd70368744177664;

  // Control that travels alongside each beat.
  typedef struct packed {
    logic valid;
    logic zero;
    logic last;
  } item_ctl_t;

  // One value per axis, x in element 0.
  typedef logic [NUM_AXES-1:0][NUM_W-1:0] axis_vec_t;
  typedef logic [NUM_AXES-1:0][POS_W-1:0] pos_vec_t;

  // Inverse extrinsic transform as loaded by software.
  typedef struct packed {
    logic [NUM_AXES-1:0][ROW_W-1:0] rot;
    logic [NUM_AXES-1:0][POS_W-1:0] shift;
  } xform_cfg_t;

endpackage

// File: hdl/bbr_numer.sv
// Front stage: forms the three dividends of the camera point from one box.
// Depends on bbr_pkg.
module bbr_numer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [15:0]              focal,
  input  logic [15:0]              person_height,
  input  logic                     feed_valid,
  input  logic [15:0]              box_x,
  input  logic [15:0]              box_y,
  input  logic [15:0]              box_width,
  input  logic [15:0]              box_height,
  input  logic                     last_box,
  output bbr_pkg::item_ctl_t       ctl,
  output bbr_pkg::axis_vec_t       numer,
  output logic [bbr_pkg::DIV_W-1:0] divisor
);
  import bbr_pkg::*;

  logic [17:0] span_x;
  logic [17:0] span_y;
  logic [33:0] prod_x;
  logic [33:0] prod_y;
  logic [31:0] prod_z;
  logic        valid;
  logic        zero;
  logic        last;

  // Twice the box centre, times the assumed height; focal length times height for z
  always_comb begin
    span_x = {1'b0, box_x, 1'b0} + {2'b00, box_width};
    span_y = {1'b0, box_y, 1'b0} + {2'b00, box_height};
    prod_x = person_height * span_x;
    prod_y = person_height * span_y;
    prod_z = focal * person_height;
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= feed_valid;
    end
  end

  // Payload; the *8 and *16 scalings are plain shifts
  always_ff @(posedge clk) begin
    if (en) begin
      zero          <= (box_height == '0);
      last          <= last_box;
      numer[AXIS_X] <= {prod_x, 3'b000};
      numer[AXIS_Y] <= {prod_y, 3'b000};
      numer[AXIS_Z] <= {1'b0, prod_z, 4'b0000};
      divisor       <= box_height;
    end
  end

  assign ctl = '{valid: valid, zero: zero, last: last};

endmodule

// File: hdl/bbr_divider.sv
// Pipelined restoring divider: three dividends over one shared divisor,
// one quotient bit per stage. Depends on bbr_pkg.
module bbr_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  bbr_pkg::item_ctl_t        ctl_in,
  input  bbr_pkg::axis_vec_t        numer,
  input  logic [bbr_pkg::DIV_W-1:0] divisor,
  output bbr_pkg::item_ctl_t        ctl_out,
  output bbr_pkg::axis_vec_t        quot
);
  import bbr_pkg::*;

  localparam int LAST = NUM_W - 1;

  // Stage registers; work holds the unused dividend bits above the
  // quotient bits found so far
  logic                               valid_pipe [NUM_W];
  logic                               zero_pipe  [NUM_W];
  logic                               last_pipe  [NUM_W];
  axis_vec_t                          work       [NUM_W];
  logic [NUM_AXES-1:0][DIV_W-1:0]     rem        [NUM_W];
  logic [DIV_W-1:0]                   dvs        [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    axis_vec_t                      work_prev;
    axis_vec_t                      work_step;
    logic [NUM_AXES-1:0][DIV_W-1:0] rem_prev;
    logic [NUM_AXES-1:0][DIV_W-1:0] rem_step;
    logic [NUM_AXES-1:0][DIV_W:0]   trial;
    logic [NUM_AXES-1:0]            ge;
    logic [DIV_W-1:0]               d_prev;
    logic                           v_prev;
    logic                           z_prev;
    logic                           l_prev;

    if (s == 0) begin : g_first
      assign work_prev = numer;
      assign rem_prev  = '0;
      assign d_prev    = divisor;
      assign v_prev    = ctl_in.valid;
      assign z_prev    = ctl_in.zero;
      assign l_prev    = ctl_in.last;
    end else begin : g_next
      assign work_prev = work[s-1];
      assign rem_prev  = rem[s-1];
      assign d_prev    = dvs[s-1];
      assign v_prev    = valid_pipe[s-1];
      assign z_prev    = zero_pipe[s-1];
      assign l_prev    = last_pipe[s-1];
    end

    // Bring down one dividend bit, subtract if it fits
    always_comb begin
      for (int j = 0; j < NUM_AXES; j++) begin
        trial[j]     = {rem_prev[j], work_prev[j][NUM_W-1]};
        ge[j]        = (trial[j] >= {1'b0, d_prev});
        rem_step[j]  = ge[j] ? DIV_W'(trial[j] - {1'b0, d_prev}) : DIV_W'(trial[j]);
        work_step[j] = {work_prev[j][NUM_W-2:0], ge[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_pipe[s] <= 1'b0;
      end else if (en) begin
        valid_pipe[s] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_pipe[s] <= z_prev;
        last_pipe[s] <= l_prev;
        work[s]      <= work_step;
        rem[s]       <= rem_step;
        dvs[s]       <= d_prev;
      end
    end
  end

  assign quot    = work[LAST];
  assign ctl_out = '{valid: valid_pipe[LAST], zero: zero_pipe[LAST], last: last_pipe[LAST]};

endmodule

// File: hdl/bbr_transform.sv
// Rigid transform of the camera point: products, two adder stages,
// floor shift and saturation into the output register. Depends on bbr_pkg.
module bbr_transform (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bbr_pkg::item_ctl_t   ctl_in,
  input  bbr_pkg::axis_vec_t   cam,
  input  bbr_pkg::xform_cfg_t  cfg,
  output bbr_pkg::item_ctl_t   ctl_out,
  output bbr_pkg::pos_vec_t    pos
);
  import bbr_pkg::*;

  localparam int HI_W = SUM_W - POS_W + 1;

  logic [2:0]                     valid_pipe;
  logic [2:0]                     zero_pipe;
  logic [2:0]                     last_pipe;
  logic signed [PROD_W-1:0]       prod   [NUM_AXES][NUM_AXES];
  logic signed [SUM_W-1:0]        pair_a [NUM_AXES];
  logic signed [SUM_W-1:0]        pair_b [NUM_AXES];
  logic signed [SUM_W-1:0]        total  [NUM_AXES];
  logic signed [SUM_W-1:0]        scaled [NUM_AXES];
  logic [NUM_AXES-1:0][HI_W-1:0]  hi;
  pos_vec_t                       pos_next;

  // Valid bits of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[1:0], ctl_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_pipe <= {zero_pipe[1:0], ctl_in.zero};
      last_pipe <= {last_pipe[1:0], ctl_in.last};
    end
  end

  // Stage 1: coefficient times camera coordinate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          prod[r][c] <= $signed(cfg.rot[r][c*COEF_W +: COEF_W]) * $signed({1'b0, cam[c]});
        end
      end
    end
  end

  // Stage 2: pairwise sums, translation aligned to Q16.30
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        pair_a[r] <= {prod[r][0][PROD_W-1], prod[r][0]} + {prod[r][1][PROD_W-1], prod[r][1]};
        pair_b[r] <= {prod[r][2][PROD_W-1], prod[r][2]}
                   + {{(SUM_W-POS_W-ROT_FRAC){cfg.shift[r][POS_W-1]}},
                      cfg.shift[r], {ROT_FRAC{1'b0}}};
      end
    end
  end

  // Stage 3: final add, floor shift, saturate; zero box height forces zero
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      total[r]  = pair_a[r] + pair_b[r];
      scaled[r] = total[r] >>> ROT_FRAC;
      hi[r]     = scaled[r][SUM_W-1:POS_W-1];
      if (zero_pipe[1]) begin
        pos_next[r] = '0;
      end else if ((&hi[r]) || !(|hi[r])) begin
        pos_next[r] = scaled[r][POS_W-1:0];
      end else if (scaled[r][SUM_W-1]) begin
        pos_next[r] = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        pos_next[r] = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos <= pos_next;
    end
  end

  assign ctl_out = '{valid: valid_pipe[2], zero: zero_pipe[2], last: last_pipe[2]};

endmodule

// File: hdl/bbr_to_robot_position_unit.sv
// Throughput: one box per cycle while the output is not stalled; the 37-stage
// divider and the three transform stages each take a new beat every cycle.
// A stalled output holds the pipeline; one beat more is caught in an input skid.
// Reset: clears all valid bits and the skid, loads the default camera
// and identity transform registers.
module bbox_to_robot_position_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // box channel
  input  logic        box_valid,
  output logic        box_ready,
  input  logic [15:0] box_x,
  input  logic [15:0] box_y,
  input  logic [15:0] box_width,
  input  logic [15:0] box_height,
  input  logic        last_box,
  // position channel
  output logic        pos_valid,
  input  logic        pos_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic        zero_height,
  output logic        last_out
);
  import bbr_pkg::*;

  logic [15:0]             focal;
  logic [15:0]             person_height;
  xform_cfg_t              xform;

  logic                    en;
  logic                    skid_valid;
  logic [15:0]             skid_x;
  logic [15:0]             skid_y;
  logic [15:0]             skid_w;
  logic [15:0]             skid_h;
  logic                    skid_last;
  logic                    feed_valid;
  logic [15:0]             feed_x;
  logic [15:0]             feed_y;
  logic [15:0]             feed_w;
  logic [15:0]             feed_h;
  logic                    feed_last;

  item_ctl_t               numer_ctl;
  axis_vec_t               numer;
  logic [DIV_W-1:0]        divisor;
  item_ctl_t               div_ctl;
  axis_vec_t               cam;
  item_ctl_t               out_ctl;
  pos_vec_t                pos_vec;

  // Configuration registers; writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal <= FOCAL_RESET;
      person_height <= HEIGHT_RESET;
      xform.rot[AXIS_X] <= ROT0_RESET;
      xform.rot[AXIS_Y] <= ROT1_RESET;
      xform.rot[AXIS_Z] <= ROT2_RESET;
      xform.shift <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOCAL:   focal <= cfg_data[15:0];
        REG_HEIGHT:  person_height <= cfg_data[15:0];
        REG_ROT0:    xform.rot[AXIS_X] <= cfg_data;
        REG_ROT1:    xform.rot[AXIS_Y] <= cfg_data;
        REG_ROT2:    xform.rot[AXIS_Z] <= cfg_data;
        REG_SHIFT_X: xform.shift[AXIS_X] <= cfg_data[31:0];
        REG_SHIFT_Y: xform.shift[AXIS_Y] <= cfg_data[31:0];
        REG_SHIFT_Z: xform.shift[AXIS_Z] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a finished beat is waiting
  assign en        = !pos_valid || pos_ready;
  assign box_ready = !skid_valid;

  // Skid stage catches the beat accepted while the pipeline is held
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (box_valid && box_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && box_valid && box_ready) begin
      skid_x    <= box_x;
      skid_y    <= box_y;
      skid_w    <= box_width;
      skid_h    <= box_height;
      skid_last <= last_box;
    end
  end

  always_comb begin
    feed_valid = skid_valid || box_valid;
    feed_x     = skid_valid ? skid_x : box_x;
    feed_y     = skid_valid ? skid_y : box_y;
    feed_w     = skid_valid ? skid_w : box_width;
    feed_h     = skid_valid ? skid_h : box_height;
    feed_last  = skid_valid ? skid_last : last_box;
  end

  bbr_numer u_numer (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .focal         (focal),
    .person_height (person_height),
    .feed_valid    (feed_valid),
    .box_x         (feed_x),
    .box_y         (feed_y),
    .box_width     (feed_w),
    .box_height    (feed_h),
    .last_box      (feed_last),
    .ctl           (numer_ctl),
    .numer         (numer),
    .divisor       (divisor)
  );

  bbr_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (numer_ctl),
    .numer   (numer),
    .divisor (divisor),
    .ctl_out (div_ctl),
    .quot    (cam)
  );

  bbr_transform u_transform (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (div_ctl),
    .cam     (cam),
    .cfg     (xform),
    .ctl_out (out_ctl),
    .pos     (pos_vec)
  );

  assign pos_valid   = out_ctl.valid;
  assign zero_height = out_ctl.zero;
  assign last_out    = out_ctl.last;
  assign pos_x       = pos_vec[AXIS_X];
  assign pos_y       = pos_vec[AXIS_Y];
  assign pos_z       = pos_vec[AXIS_Z];

  // A flagged box always comes out at the origin
  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    pos_valid && zero_height |-> pos_x == 0 && pos_y == 0 && pos_z == 0)
    else $error("zero-height beat with non-zero position");

  // A beat taken while held fills the skid and closes the input
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    box_valid && box_ready && !en |=> !box_ready)
    else $error("beat accepted under stall did not fill the skid");

  // The skid only holds a beat while a result waits
  a_skid_held: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> pos_valid)
    else $error("skid full with no waiting result");

  // Reset loads the default camera registers
  a_cfg_reset: assert property (@(posedge clk)
    rst |=> focal == FOCAL_RESET && person_height == HEIGHT_RESET)
    else $error("camera registers not at reset value");

endmodule

// File: bench/bbox_checker.sv
// Checker for the box-to-robot-position unit: watches the config, box and position channels,
// predicts each position from its own copy of the registers and compares beat by beat.
// Depends on bbr_pkg for register indexes, reset values and widths.
module bbox_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        box_valid,
  input  logic        box_ready,
  input  logic [15:0] box_x,
  input  logic [15:0] box_y,
  input  logic [15:0] box_width,
  input  logic [15:0] box_height,
  input  logic        last_box,
  input  logic        pos_valid,
  input  logic        pos_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic        zero_height,
  input  logic        last_out,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbr_pkg::*;

  localparam int     MAX_REPORTS = 30;
  localparam longint POS_MAX     = 64'sd2147483647;
  localparam longint POS_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero;
    logic               last;
  } position_t;

  // Shadow of the register file
  logic [15:0]                    focal;
  logic [15:0]                    person_h;
  logic [NUM_AXES-1:0][ROW_W-1:0] rot_rows;
  logic [NUM_AXES-1:0][POS_W-1:0] shifts;

  position_t positions_due[$];

  // One row of the rigid transform in Q16.30, floored back to Q16.16 and saturated
  function automatic logic signed [31:0] rotate_axis(logic [ROW_W-1:0] row,
                                                     logic [POS_W-1:0] shift,
                                                     longint cx, longint cy, longint cz);
    longint acc;
    acc = longint'($signed(row[15:0]))  * cx
        + longint'($signed(row[31:16])) * cy
        + longint'($signed(row[47:32])) * cz
        + (longint'($signed(shift)) <<< ROT_FRAC);
    acc = acc >>> ROT_FRAC;
    if (acc > POS_MAX) acc = POS_MAX;
    if (acc < POS_MIN) acc = POS_MIN;
    return 32'(acc);
  endfunction

  // Back-project the box through the pinhole model, then into the robot frame
  function automatic position_t predict_position(logic [15:0] bx, logic [15:0] by,
                                                 logic [15:0] bw, logic [15:0] bh,
                                                 logic last);
    position_t p;
    longint    h;
    longint    cx;
    longint    cy;
    longint    cz;
    p.last = last;
    if (bh == 16'd0) begin
      p.x    = '0;
      p.y    = '0;
      p.z    = '0;
      p.zero = 1'b1;
      return p;
    end
    h  = longint'(bh);
    cz = (longint'(focal) * longint'(person_h) * 16) / h;
    cx = (longint'(person_h) * (2 * longint'(bx) + longint'(bw)) * 8) / h;
    cy = (longint'(person_h) * (2 * longint'(by) + longint'(bh)) * 8) / h;
    p.x    = rotate_axis(rot_rows[AXIS_X], shifts[AXIS_X], cx, cy, cz);
    p.y    = rotate_axis(rot_rows[AXIS_Y], shifts[AXIS_Y], cx, cy, cz);
    p.z    = rotate_axis(rot_rows[AXIS_Z], shifts[AXIS_Z], cx, cy, cz);
    p.zero = 1'b0;
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Compare one position beat with the oldest outstanding prediction
  task automatic check_position();
    position_t want;
    if (positions_due.size() == 0) begin
      report_mismatch("position beat with nothing outstanding", pos_x, '0);
      return;
    end
    want = positions_due.pop_front();
    if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
    if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
    if (pos_z !== want.z) report_mismatch("pos_z", pos_z, want.z);
    if (zero_height !== want.zero) report_mismatch("zero_height", zero_height, want.zero);
    if (last_out !== want.last) report_mismatch("last_out", last_out, want.last);
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      focal              = FOCAL_RESET;
      person_h           = HEIGHT_RESET;
      rot_rows[AXIS_X]   = ROT0_RESET;
      rot_rows[AXIS_Y]   = ROT1_RESET;
      rot_rows[AXIS_Z]   = ROT2_RESET;
      shifts             = '0;
      mismatches         = 0;
      positions_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FOCAL:   focal            = cfg_data[15:0];
          REG_HEIGHT:  person_h         = cfg_data[15:0];
          REG_ROT0:    rot_rows[AXIS_X] = cfg_data;
          REG_ROT1:    rot_rows[AXIS_Y] = cfg_data;
          REG_ROT2:    rot_rows[AXIS_Z] = cfg_data;
          REG_SHIFT_X: shifts[AXIS_X]   = cfg_data[31:0];
          REG_SHIFT_Y: shifts[AXIS_Y]   = cfg_data[31:0];
          REG_SHIFT_Z: shifts[AXIS_Z]   = cfg_data[31:0];
          default: ;  // unknown index: write dropped
        endcase
      end
      if (box_valid && box_ready)
        positions_due.insert(positions_due.size(),
                             predict_position(box_x, box_y, box_width, box_height,
                                              last_box));
      if (pos_valid && pos_ready)
        check_position();
    end
    pending = positions_due.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the bench: clock, reset, register loads, box stimulus and position back-pressure.
// Instantiates bbox_to_robot_position_unit and bbox_checker; needs bbr_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bbr_pkg::*;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int FLOOD_ITEMS      = 120;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic        last;
  } box_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        box_valid;
  logic        box_ready;
  logic [15:0] box_x;
  logic [15:0] box_y;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic        last_box;
  logic        pos_valid;
  logic        pos_ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        zero_height;
  logic        last_out;

  int mismatches;
  int pending;
  int cycle_count;
  int send_idle;
  int recv_idle;
  int hold_request;

  logic [47:0] reg_vals [8];

  bbox_to_robot_position_unit dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .box_valid, .box_ready, .box_x, .box_y, .box_width, .box_height, .last_box,
    .pos_valid, .pos_ready, .pos_x, .pos_y, .pos_z, .zero_height, .last_out
  );

  bbox_checker u_checker (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .box_valid, .box_ready, .box_x, .box_y, .box_width, .box_height, .last_box,
    .pos_valid, .pos_ready, .pos_x, .pos_y, .pos_z, .zero_height, .last_out,
    .mismatches, .pending
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Position receiver: random stalls, plus one long hold-off on request
  initial begin
    pos_ready    = 1'b0;
    hold_request = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_request = 0;
        pos_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pos_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one box beat, with random idle cycles ahead of it; enter and leave at a falling edge
  task automatic send_box(input box_t b);
    while ($urandom_range(99) < send_idle) begin
      box_valid <= 1'b0;
      @(negedge clk);
    end
    box_valid  <= 1'b1;
    box_x      <= b.x;
    box_y      <= b.y;
    box_width  <= b.w;
    box_height <= b.h;
    last_box   <= b.last;
    do @(posedge clk); while (!box_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every position has come back
  task automatic wait_drained();
    box_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // Write every register from reg_vals, then a random unused index, which must be dropped
  task automatic load_registers();
    for (int i = REG_FOCAL; i <= REG_SHIFT_Z + 1; i++) begin
      cfg_valid <= 1'b1;
      if (i > REG_SHIFT_Z) begin
        cfg_index <= 4'(REG_SHIFT_Z + 1 + $urandom_range(7));
        cfg_data  <= 48'({$urandom(), $urandom()});
      end else begin
        cfg_index <= 4'(i);
        cfg_data  <= reg_vals[i];
      end
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] random48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic randomise_registers();
    for (int i = REG_FOCAL; i <= REG_SHIFT_Z; i++)
      reg_vals[i] = random48();
    if (reg_vals[REG_FOCAL][15:0] < 16'd16) reg_vals[REG_FOCAL][15:0] = 16'd16;
    if (reg_vals[REG_HEIGHT][15:0] == 16'd0) reg_vals[REG_HEIGHT][15:0] = 16'd1;
    // keep the usual camera values most of the time so positions rarely saturate
    if ($urandom_range(2) != 0) begin
      reg_vals[REG_FOCAL][15:0]  = 16'($urandom_range(65535, 4000));
      reg_vals[REG_HEIGHT][15:0] = 16'($urandom_range(8192, 4096));
    end
  endtask

  // Mostly plausible detections; some zero, tiny or fully random heights
  function automatic box_t random_box();
    box_t b;
    int   kind;
    kind   = $urandom_range(9);
    b.last = ($urandom_range(7) == 0);
    b.x    = 16'($urandom());
    b.y    = 16'($urandom());
    b.w    = 16'($urandom());
    case (kind)
      0: b.h = '0;
      1: b.h = 16'($urandom());
      2: b.h = 16'($urandom_range(15, 1));
      default: begin
        b.x = 16'($urandom_range(1920 * 16));
        b.y = 16'($urandom_range(1080 * 16));
        b.w = 16'($urandom_range(400 * 16, 16));
        b.h = 16'($urandom_range(800 * 16, 16));
      end
    endcase
    return b;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_box(random_box());
  endtask

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    box_valid  = 1'b0;
    box_x      = '0;
    box_y      = '0;
    box_width  = '0;
    box_height = '0;
    last_box   = 1'b0;
    send_idle  = 32;
    recv_idle  = 62;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed boxes under the reset registers
    send_box('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1});  // zero height
    send_box('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0});  // zero height, rest full
    send_box('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b1});  // saturates high
    send_box('{16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b0});
    send_box('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
    send_box('{16'd10240, 16'd3200, 16'd1280, 16'd3840, 1'b1});  // typical person
    wait_drained();

    // Extreme registers: largest camera, full-scale coefficients, extreme shifts
    reg_vals[REG_FOCAL]   = 48'hFFFF;
    reg_vals[REG_HEIGHT]  = 48'hFFFF;
    reg_vals[REG_ROT0]    = {16'h7FFF, 16'h7FFF, 16'h7FFF};
    reg_vals[REG_ROT1]    = {16'h8000, 16'h8000, 16'h8000};
    reg_vals[REG_ROT2]    = {16'h0000, 16'h7FFF, 16'h8000};
    reg_vals[REG_SHIFT_X] = 48'h7FFF_FFFF;
    reg_vals[REG_SHIFT_Y] = 48'h8000_0000;
    reg_vals[REG_SHIFT_Z] = 48'hFFFF_FFFF;
    load_registers();
    send_box('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b0});  // saturates both ways
    send_box('{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1});
    send_box('{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0});
    send_box('{16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 1'b0});
    send_box('{16'd10240, 16'd3200, 16'd1280, 16'd3840, 1'b1});
    wait_drained();

    // Smallest camera; shifts of -1, +1 and the most negative value
    reg_vals[REG_FOCAL]   = 48'd16;
    reg_vals[REG_HEIGHT]  = 48'd1;
    reg_vals[REG_ROT0]    = {16'h0000, 16'h0000, 16'hC000};
    reg_vals[REG_ROT1]    = {16'h0000, 16'h4000, 16'h0000};
    reg_vals[REG_ROT2]    = {16'hC000, 16'h0000, 16'h0000};
    reg_vals[REG_SHIFT_X] = 48'hFFFF_FFFF;
    reg_vals[REG_SHIFT_Y] = 48'h0000_0001;
    reg_vals[REG_SHIFT_Z] = 48'h8000_0000;
    load_registers();
    send_box('{16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0});  // floors a negative sum
    send_box('{16'h0003, 16'h0000, 16'h0000, 16'hFFFF, 1'b1});
    send_box('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0});
    send_box('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1});
    send_box('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    wait_drained();

    // Random phase: sender idles lightly, receiver heavily; one pause to drain midway
    randomise_registers();
    load_registers();
    send_random(RANDOM_PER_PHASE / 2);
    wait_drained();
    send_random(RANDOM_PER_PHASE / 2);
    wait_drained();

    // Random phase: idling swapped
    send_idle = 62;
    recv_idle = 32;
    randomise_registers();
    load_registers();
    send_random(RANDOM_PER_PHASE);
    wait_drained();

    // Random phase without idling; a long receiver hold-off fills the pipeline first
    send_idle = 0;
    recv_idle = 0;
    randomise_registers();
    load_registers();
    hold_request = 1;
    send_random(FLOOD_ITEMS);
    wait_drained();
    send_random(RANDOM_PER_PHASE - FLOOD_ITEMS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/bbr_pkg.sv
hdl/bbr_numer.sv
hdl/bbr_divider.sv
hdl/bbr_transform.sv
hdl/bbr_to_robot_position_unit.sv
bench/bbox_checker.sv
bench/testbench.sv
